### rtl/core/cfa_pkg.sv
// Package: shared types and status codes of the contiguous frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package cfa_pkg;
    localparam int unsigned OwnerW = 5;
    localparam int unsigned StatusW = 3;
    localparam int unsigned CountW = 9;
    localparam int unsigned StartW = 8;
    localparam int unsigned ModeW = 2;

    typedef enum logic [StatusW-1:0] {
        ST_PLACED    = 3'd0,
        ST_COMPACTED = 3'd1,
        ST_SKIPPED   = 3'd2,
        ST_FREED     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    typedef enum logic [ModeW-1:0] {
        MODE_NEXT  = 2'd0,
        MODE_BEST  = 2'd1,
        MODE_WORST = 2'd2,
        MODE_ALT   = 2'd3
    } mode_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
endpackage
`default_nettype wire

### rtl/core/contiguous_frame_allocator_core.sv
// Top level: contiguous frame allocator with next, best and worst fit plus compaction.
//
// Usage:
//  - Request channel: raise start with operation, owner_id and frames_needed
//    while busy is low; the request is taken at that edge and busy rises.
//  - Result channel: done pulses for one cycle with status, start_frame,
//    frames_moved and frames_changed. The receiver cannot stall; busy stays
//    high through the done cycle and falls in the cycle after it, so the next
//    request is taken at the edge that ends that idle cycle.
//  - Configuration: cfg_valid/cfg_ready write placement_mode; cfg_ready is
//    high whenever no request is in flight, start is low and no clearing
//    pass runs.
//  - Rate: one request walks the owner map (one RAM port, one frame per
//    cycle) in each pass. A free is one pass with the clears made in flight.
//    Best and worst fit scan once, next fit up to twice (from next_pointer,
//    then from frame 0), then write one frame per cycle. A compacting
//    allocation adds a count pass, a slide pass, a pass zeroing the tail and
//    the fill.
//  - Reset: the owner map is held in a RAM; after rst_n rises a clearing
//    pass writes every frame free, with busy high throughout. next_pointer
//    and placement_mode clear at once.
`timescale 1ns / 1ps
`default_nettype none
module contiguous_frame_allocator_core #(
    parameter int unsigned NUM_FRAMES = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       operation,
    input  wire logic [4:0] owner_id,
    input  wire logic [8:0] frames_needed,
    output logic            done,
    output logic [2:0]      status,
    output logic [7:0]      start_frame,
    output logic [8:0]      frames_moved,
    output logic [8:0]      frames_changed,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_data
);
    localparam int unsigned AW = $clog2(NUM_FRAMES);
    // frame counters must hold NUM_FRAMES itself plus headroom for pos+need
    localparam int unsigned FW = $clog2(NUM_FRAMES + 512) + 1;
    localparam logic [FW-1:0] NF = FW'(NUM_FRAMES);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_SCAN  = 11'b00000000100,
        S_EVAL  = 11'b00000001000,
        S_FILL  = 11'b00000010000,
        S_FREE  = 11'b00000100000,
        S_COUNT = 11'b00001000000,
        S_SLIDE = 11'b00010000000,
        S_ZERO  = 11'b00100000000,
        S_PLACE = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // RAM port signals
    logic              we;
    logic [AW-1:0]     wa, ra;
    logic [4:0]        wd, rd;

    cfa_ram #(.WIDTH(cfa_pkg::OwnerW), .DEPTH(NUM_FRAMES)) u_map (
        .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(wd),
        .rd_addr(ra), .rd_data(rd)
    );

    logic [1:0]    mode_reg;
    logic [FW-1:0] nptr_reg;
    logic [4:0]    own_reg;
    logic [FW-1:0] need_reg;
    logic          pass2_reg;   // next-fit second pass from frame 0
    logic [FW-1:0] rcnt_reg;    // read address counter (issued)
    logic [FW-1:0] fcnt_reg;    // frame index of data arriving on rd
    logic          rv_reg;      // rd holds valid data for fcnt_reg
    logic [FW-1:0] run_reg, rstart_reg;
    logic          found_reg;
    logic [FW-1:0] blen_reg, bpos_reg;
    logic [FW-1:0] wcnt_reg;    // write pointer / fill pointer
    logic [FW-1:0] free_reg;
    logic [FW-1:0] moved_reg;
    logic          mseen_reg;   // free: owner run seen
    logic [2:0]    st_reg;
    logic [FW-1:0] sf_reg, chg_reg;

    logic mode_next_fit;
    assign mode_next_fit = (mode_reg == cfa_pkg::MODE_NEXT) || (mode_reg == cfa_pkg::MODE_ALT);

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !start;

    // hole-scan evaluation of the incoming frame (rd, index fcnt_reg)
    logic          at_end;      // the frame beyond the map closes the run
    logic          is_free;
    logic          close_run;
    logic          fits;
    logic          better;
    assign at_end   = (fcnt_reg == NF);
    assign is_free  = !at_end && (rd == '0);
    assign close_run = rv_reg && !is_free && (run_reg != '0);
    assign fits     = close_run && (run_reg >= need_reg);
    assign better   = !found_reg
                   || ((mode_reg == cfa_pkg::MODE_BEST) && (run_reg < blen_reg))
                   || ((mode_reg == cfa_pkg::MODE_WORST) && (run_reg > blen_reg));

    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        wa = wcnt_reg[AW-1:0];
        wd = '0;
        ra = rcnt_reg[AW-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                if (wcnt_reg == NF - FW'(1)) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == cfa_pkg::OP_FREE)
                        state_next = (owner_id == '0) ? S_DONE : S_FREE;
                    else if (owner_id == '0 || frames_needed == '0)
                        state_next = S_DONE;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rv_reg && mode_next_fit && fits) state_next = S_FILL;
                else if (rv_reg && at_end) state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (mode_next_fit && !pass2_reg) state_next = S_SCAN;
                else if (found_reg) state_next = S_FILL;
                else state_next = S_COUNT;
            end
            S_FILL:
            begin
                we = 1'b1;
                wd = own_reg;
                if (wcnt_reg + FW'(1) >= chg_reg + sf_reg) state_next = S_DONE;
            end
            S_FREE:
            begin
                if (rv_reg && !at_end && rd == own_reg)
                begin
                    we = 1'b1;
                    wa = fcnt_reg[AW-1:0];
                end
                if (rv_reg && (at_end || (mseen_reg && rd != own_reg)))
                    state_next = S_DONE;
            end
            S_COUNT:
            begin
                if (rv_reg && at_end)
                    state_next = (need_reg > free_reg) ? S_DONE : S_SLIDE;
            end
            S_SLIDE:
            begin
                // read ahead and write lower; wcnt <= fcnt so no hazard
                if (rv_reg && !at_end && rd != '0)
                begin
                    we = 1'b1;
                    wd = rd;
                end
                if (rv_reg && at_end) state_next = S_ZERO;
            end
            S_ZERO:
            begin
                if (wcnt_reg < NF)
                    we = 1'b1;
                else
                    state_next = S_PLACE;
            end
            S_PLACE:
            begin
                if (wcnt_reg < NF && wcnt_reg < sf_reg + chg_reg)
                begin
                    we = 1'b1;
                    wd = own_reg;
                end
                else
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done           = (state_reg == S_DONE);
    assign status         = st_reg;
    assign start_frame    = sf_reg[7:0];
    assign frames_moved   = moved_reg[8:0];
    assign frames_changed = chg_reg[8:0];

    // state, mode, read stream and per-state datapath registers; each pass restarts the read stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            mode_reg  <= '0;
            nptr_reg  <= '0;
            wcnt_reg  <= '0;
            rcnt_reg  <= '0;
            fcnt_reg  <= '0;
            rv_reg    <= 1'b0;
            st_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) mode_reg <= cfg_data;

            // read stream: issue rcnt, data for it appears next cycle
            if (state_reg == S_SCAN || state_reg == S_FREE || state_reg == S_COUNT
                || state_reg == S_SLIDE)
            begin
                if (rcnt_reg <= NF)
                begin
                    fcnt_reg <= rcnt_reg;
                    rv_reg   <= 1'b1;
                    rcnt_reg <= rcnt_reg + FW'(1);
                end
                else
                    rv_reg <= 1'b0;
            end
            else
                rv_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    wcnt_reg <= wcnt_reg + FW'(1);
                end
                S_IDLE:
                begin
                    own_reg   <= owner_id;
                    need_reg  <= FW'(frames_needed);
                    run_reg   <= '0;
                    found_reg <= 1'b0;
                    blen_reg  <= '0;
                    bpos_reg  <= '0;
                    mseen_reg <= 1'b0;
                    free_reg  <= '0;
                    moved_reg <= '0;
                    sf_reg    <= '0;
                    chg_reg   <= '0;
                    if (mode_next_fit && operation == cfa_pkg::OP_ALLOC
                        && nptr_reg < NF)
                    begin
                        rcnt_reg  <= nptr_reg;
                        pass2_reg <= 1'b0;
                    end
                    else
                    begin
                        rcnt_reg  <= '0;
                        pass2_reg <= 1'b1;
                    end
                    st_reg <= (operation == cfa_pkg::OP_FREE) ? cfa_pkg::ST_NOT_FOUND
                                                              : cfa_pkg::ST_SKIPPED;
                end
                S_SCAN:
                begin
                    if (rv_reg)
                    begin
                        if (is_free)
                        begin
                            if (run_reg == '0) rstart_reg <= fcnt_reg;
                            run_reg <= run_reg + FW'(1);
                        end
                        else
                        begin
                            run_reg <= '0;
                            if (fits && better)
                            begin
                                found_reg <= 1'b1;
                                blen_reg  <= run_reg;
                                bpos_reg  <= rstart_reg;
                            end
                        end
                        if (mode_next_fit && fits)
                        begin
                            wcnt_reg <= rstart_reg;
                            sf_reg   <= rstart_reg;
                            chg_reg  <= need_reg;
                            st_reg   <= cfa_pkg::ST_PLACED;
                            nptr_reg <= rstart_reg + need_reg;
                        end
                    end
                end
                S_EVAL:
                begin
                    run_reg <= '0;
                    if (mode_next_fit && !pass2_reg)
                    begin
                        pass2_reg <= 1'b1;
                        rcnt_reg  <= '0;
                    end
                    else if (found_reg)
                    begin
                        wcnt_reg <= bpos_reg;
                        sf_reg   <= bpos_reg;
                        chg_reg  <= need_reg;
                        st_reg   <= cfa_pkg::ST_PLACED;
                    end
                    else
                        rcnt_reg <= '0;
                end
                S_FILL:
                begin
                    wcnt_reg <= wcnt_reg + FW'(1);
                end
                S_FREE:
                begin
                    if (rv_reg && !at_end && rd == own_reg)
                    begin
                        if (!mseen_reg)
                        begin
                            sf_reg <= fcnt_reg;
                            st_reg <= cfa_pkg::ST_FREED;
                        end
                        mseen_reg <= 1'b1;
                        chg_reg   <= chg_reg + FW'(1);
                    end
                end
                S_COUNT:
                begin
                    if (rv_reg && is_free) free_reg <= free_reg + FW'(1);
                    if (rv_reg && at_end)
                    begin
                        rcnt_reg <= '0;
                        wcnt_reg <= '0;
                    end
                end
                S_SLIDE:
                begin
                    if (rv_reg && !at_end && rd != '0)
                    begin
                        if (wcnt_reg != fcnt_reg) moved_reg <= moved_reg + FW'(1);
                        wcnt_reg <= wcnt_reg + FW'(1);
                    end
                    if (rv_reg && at_end)
                    begin
                        sf_reg  <= wcnt_reg;
                        chg_reg <= need_reg;
                        st_reg  <= cfa_pkg::ST_COMPACTED;
                        if (mode_next_fit) nptr_reg <= wcnt_reg + need_reg;
                    end
                end
                S_ZERO:
                begin
                    if (wcnt_reg < NF) wcnt_reg <= wcnt_reg + FW'(1);
                    else wcnt_reg <= sf_reg;
                end
                S_PLACE:
                begin
                    wcnt_reg <= wcnt_reg + FW'(1);
                end
                S_DONE:
                begin
                    rcnt_reg <= '0;
                end
                default:
                begin
                    rcnt_reg <= '0;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/cfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module cfa_ram #(
    parameter int unsigned WIDTH = 5,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### rtl/core/cfa_checker.sv
// Checker: port-level properties of the frame allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cfa_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [2:0] status,
    input wire logic [7:0] start_frame,
    input wire logic [8:0] frames_moved,
    input wire logic [8:0] frames_changed,
    input wire logic       cfg_ready
);
    // an accepted request raises busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    // a result only while a request is in flight
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done without request");
    // done is a single pulse
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    // skipped or not found carry zero fields
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status == cfa_pkg::ST_SKIPPED || status == cfa_pkg::ST_NOT_FOUND)
        |-> start_frame == '0 && frames_changed == '0 && frames_moved == '0)
        else $error("nonzero fields");
    // configuration only accepted when idle
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !busy) else $error("cfg while busy");
endmodule

bind contiguous_frame_allocator_core cfa_checker u_cfa_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .start_frame(start_frame), .frames_moved(frames_moved),
    .frames_changed(frames_changed), .cfg_ready(cfg_ready)
);
`default_nettype wire
